### hdl/hits_pkg.sv
// shared types and codes for the heap-indexed tree store
package hits_pkg;
   localparam logic [3:0] OP_INIT = 4'd0, OP_SETL = 4'd1, OP_SETR = 4'd2, OP_SWAP = 4'd3,
      OP_RMLEAF = 4'd4, OP_GET = 4'd5, OP_PARENT = 4'd6, OP_LEFT = 4'd7, OP_RIGHT = 4'd8,
      OP_ISINT = 4'd9, OP_DEPTH = 4'd10, OP_HEIGHT = 4'd11, OP_SIZE = 4'd12,
      OP_PRE = 4'd13, OP_IN = 4'd14, OP_POST = 4'd15;
   localparam logic [2:0] ST_OK = 3'd0, ST_BADIDX = 3'd1, ST_EMPTY = 3'd2,
      ST_ROOTPAR = 3'd3, ST_RMROOT = 3'd4, ST_RMINT = 3'd5, ST_NOSUCC = 3'd6;
   localparam int IDX_BITS = 8;

   // commands from controller to datapath
   typedef struct packed {
      logic       rd_node;   // read memory at node
      logic       rd_alt;    // read memory at alt address
      logic       wr_a;      // write item_value at alt address
      logic       wr_swap_a; // write latched b item at node
      logic       wr_swap_b; // write latched a item at other
      logic       cap_a;     // capture read data as item a
      logic       cap_b;     // capture read data as item b
   } cmd_type;
endpackage

### hdl/heap_indexed_tree_store_unit.sv
// top level: csr port, controller and item memory
//  channel | ports                       | direction
//  req     | req_valid/ready + fields    | in
//  rsp     | rsp_valid/ready + fields    | out
//  csr     | csr_psel..csr_pready        | config
// a swap reads both items and then writes them back, one at a time (one memory port).
// walks take one level a cycle, at most eight levels; height and size sweep nodes 255
// down to the target, reading the child entries and then writing the node for each.
// reset clears all valid bits at once; the next word is taken only after the result
// leaves, so a stalled result holds off the input.
module heap_indexed_tree_store_unit #(
   parameter int CAPACITY  = 255,
   parameter int ITEM_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [3:0]           req_op,
   input  logic [7:0]           req_node_index,
   input  logic [7:0]           req_other_index,
   input  logic signed [31:0]   req_item_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic signed [31:0]   rsp_item_out,
   output logic [7:0]           rsp_index_out,
   output logic [7:0]           rsp_count_out,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [1:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import hits_pkg::*;
   logic [7:0] tlen_ff;
   cmd_type cmd;
   logic [IDX_BITS-1:0] an, aa;
   logic [31:0] rd_item;
   logic use_item;
   logic [ITEM_BITS-1:0] wr_item;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {24'd0, tlen_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) tlen_ff <= 8'd255;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         tlen_ff <= csr_pwdata[7:0];
   end

   assign wr_item = ITEM_BITS'(req_item_value);

   // item_value is held stable by the sender only until acceptance, so latch it
   logic [ITEM_BITS-1:0] val_ff;
   always_ff @(posedge clock) if (req_valid && req_ready) val_ff <= wr_item;

   hits_controller #(.CAPACITY(CAPACITY)) u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_node_index,
      .req_other_index, .tree_length(tlen_ff), .rsp_valid, .rsp_ready, .rsp_status,
      .rsp_use_item(use_item), .rsp_index_out, .rsp_count_out, .cmd,
      .addr_node(an), .addr_alt(aa));

   hits_datapath #(.ITEM_BITS(ITEM_BITS)) u_dp (
      .clock, .cmd, .addr_node(an), .addr_alt(aa), .wr_item(val_ff), .rd_item);

   assign rsp_item_out = use_item ? rd_item : 32'sd0;
endmodule

### hdl/hits_datapath.sv
// item memory with registered read, swap latches
module hits_datapath #(
   parameter int ITEM_BITS = 32
) (
   input  logic                          clock,
   input  hits_pkg::cmd_type             cmd,
   input  logic [hits_pkg::IDX_BITS-1:0] addr_node,
   input  logic [hits_pkg::IDX_BITS-1:0] addr_alt,
   input  logic [ITEM_BITS-1:0]          wr_item,
   output logic [31:0]                   rd_item
);
   import hits_pkg::*;
   logic [ITEM_BITS-1:0] mem [0:255];
   logic [ITEM_BITS-1:0] rdata_ff, a_ff, b_ff;
   logic [IDX_BITS-1:0]  raddr;

   assign raddr = cmd.rd_alt ? addr_alt : addr_node;

   always_ff @(posedge clock) begin
      if (cmd.rd_node || cmd.rd_alt) rdata_ff <= mem[raddr];
      if (cmd.wr_a) mem[addr_alt] <= wr_item;
      else if (cmd.wr_swap_a) mem[addr_node] <= b_ff;
      else if (cmd.wr_swap_b) mem[addr_alt] <= a_ff;
      if (cmd.cap_a) a_ff <= rdata_ff;
      if (cmd.cap_b) b_ff <= rdata_ff;
   end

   // sign-extend from item width to output width
   assign rd_item = 32'(signed'(rdata_ff));
endmodule

### hdl/hits_controller.sv
// command sequencer: checks, tree walks, valid bits and result formation
module hits_controller #(
   parameter int CAPACITY = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [3:0]                    req_op,
   input  logic [7:0]                    req_node_index,
   input  logic [7:0]                    req_other_index,
   input  logic [7:0]                    tree_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_use_item,
   output logic [7:0]                    rsp_index_out,
   output logic [7:0]                    rsp_count_out,
   output hits_pkg::cmd_type             cmd,
   output logic [hits_pkg::IDX_BITS-1:0] addr_node,
   output logic [hits_pkg::IDX_BITS-1:0] addr_alt
);
   import hits_pkg::*;
   localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RD = 4'd2, S_RD2 = 4'd3,
      S_SW1 = 4'd4, S_WALK = 4'd6, S_SCAN = 4'd7, S_DONE = 4'd8,
      S_CLR = 4'd9, S_SW0 = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [255:0] vld_ff, vld_in;
   logic [3:0] op_ff, op_in;
   logic [7:0] a_ff, a_in, b_ff, b_in, cur_ff, cur_in, acc_ff, acc_in;
   logic [8:0] scan_ff, scan_in;
   logic ph_ff, ph_in;
   logic [7:0] hgt_ff [0:255];
   logic [7:0] siz_ff [0:255];
   logic [7:0] hgt_l_ff, hgt_r_ff, siz_l_ff, siz_r_ff;
   logic [7:0] hgt_wr, siz_wr;
   logic hs_we;
   logic [2:0] st_ff, st_in;
   logic ui_ff, ui_in, rv_ff, rv_in;
   logic [7:0] limit;

   function automatic logic pres(input logic [255:0] v, input logic [8:0] i,
                                 input logic [7:0] lim);
      pres = (i >= 9'd1) && (i <= {1'b0, lim}) && v[i[7:0]];
   endfunction

   assign limit = (CAPACITY < 255 && tree_length > 8'(CAPACITY)) ? 8'(CAPACITY) : tree_length;
   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_use_item = ui_ff;
   assign rsp_index_out = cur_ff;
   assign rsp_count_out = acc_ff;
   assign addr_node = a_ff;
   assign addr_alt = b_ff;

   logic [8:0] l2, r2, lc, rc, pp, pr;
   logic inr_a, inr_b;
   logic [7:0] sc;
   logic [8:0] sl, sr;
   assign l2 = {a_ff, 1'b0};
   assign r2 = {a_ff, 1'b1};
   assign lc = {cur_ff, 1'b0};
   assign rc = {cur_ff, 1'b1};
   assign pp = {2'b0, cur_ff[7:1]};
   assign pr = {1'b0, cur_ff[7:1], 1'b1};
   assign inr_a = a_ff != 0 && a_ff <= limit;
   assign inr_b = b_ff != 0 && b_ff <= limit;
   assign sc = scan_ff[7:0];
   assign sl = {sc, 1'b0};
   assign sr = {sc, 1'b1};

   always_comb begin
      logic hl, hr;
      logic [7:0] hv, lh, rh;
      hl = pres(vld_ff, sl, limit);
      hr = pres(vld_ff, sr, limit);
      lh = hl ? hgt_l_ff + 8'd1 : 8'd0;
      rh = hr ? hgt_r_ff + 8'd1 : 8'd0;
      hv = (lh > rh) ? lh : rh;
      hgt_wr = hv;
      siz_wr = 8'd1 + (hl ? siz_l_ff : 8'd0) + (hr ? siz_r_ff : 8'd0);
      hs_we = (state_ff == S_SCAN) && ph_ff;
   end

   // child entries are registered, so they come back in the cycle after the node address is set
   always_ff @(posedge clock) begin
      if (hs_we) begin
         hgt_ff[sc] <= hgt_wr;
         siz_ff[sc] <= siz_wr;
      end
      hgt_l_ff <= hgt_ff[sl[7:0]];
      hgt_r_ff <= hgt_ff[sr[7:0]];
      siz_l_ff <= siz_ff[sl[7:0]];
      siz_r_ff <= siz_ff[sr[7:0]];
   end

   always_comb begin
      state_in = state_ff; vld_in = vld_ff; op_in = op_ff; a_in = a_ff; b_in = b_ff;
      cur_in = cur_ff; acc_in = acc_ff; scan_in = scan_ff; st_in = st_ff;
      ui_in = ui_ff; rv_in = rv_ff; ph_in = ph_ff; cmd = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_op; a_in = req_node_index; b_in = req_other_index;
               st_in = ST_OK; ui_in = 1'b0; cur_in = '0; acc_in = '0;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_DONE;
            if (op_ff == OP_INIT) begin
               if (limit == 0) st_in = ST_BADIDX;
               else begin
                  vld_in = '0; b_in = 8'd1; state_in = S_RD2;
               end
            end else if (op_ff == OP_SWAP) begin
               if (!inr_a || !inr_b) st_in = ST_BADIDX;
               else if (!vld_ff[a_ff] || !vld_ff[b_ff]) st_in = ST_EMPTY;
               else begin cmd.rd_node = 1'b1; state_in = S_SW0; end
            end else if (!inr_a) st_in = ST_BADIDX;
            else if (op_ff == OP_RMLEAF && a_ff == 1) st_in = ST_RMROOT;
            else if (!vld_ff[a_ff]) st_in = ST_EMPTY;
            else begin
               case (op_ff)
                  OP_SETL, OP_SETR: begin
                     if (op_ff == OP_SETR ? (r2 > {1'b0, limit}) : (l2 > {1'b0, limit}))
                        st_in = ST_BADIDX;
                     else begin
                        b_in = (op_ff == OP_SETR) ? r2[7:0] : l2[7:0];
                        state_in = S_RD2;
                     end
                  end
                  OP_RMLEAF: begin
                     if (pres(vld_ff, l2, limit) || pres(vld_ff, r2, limit)) st_in = ST_RMINT;
                     else begin
                        vld_in[a_ff] = 1'b0; cmd.rd_node = 1'b1; ui_in = 1'b1;
                        state_in = S_RD;
                     end
                  end
                  OP_GET: begin cmd.rd_node = 1'b1; ui_in = 1'b1; state_in = S_RD; end
                  OP_PARENT: begin
                     if (a_ff == 1) st_in = ST_ROOTPAR;
                     else if (!pres(vld_ff, {2'b0, a_ff[7:1]}, limit)) st_in = ST_EMPTY;
                     else begin
                        b_in = {1'b0, a_ff[7:1]}; state_in = S_RD2;
                     end
                  end
                  OP_LEFT, OP_RIGHT: begin
                     if ((op_ff == OP_RIGHT ? r2 : l2) > {1'b0, limit}) st_in = ST_BADIDX;
                     else if (!vld_ff[(op_ff == OP_RIGHT) ? r2[7:0] : l2[7:0]]) st_in = ST_EMPTY;
                     else begin
                        b_in = (op_ff == OP_RIGHT) ? r2[7:0] : l2[7:0];
                        state_in = S_RD2;
                     end
                  end
                  OP_ISINT: acc_in = {7'd0, pres(vld_ff, l2, limit) || pres(vld_ff, r2, limit)};
                  OP_DEPTH: begin cur_in = a_ff; state_in = S_WALK; end
                  OP_HEIGHT, OP_SIZE: begin
                     scan_in = 9'd255; ph_in = 1'b0; state_in = S_SCAN;
                  end
                  default: begin
                     cur_in = a_ff; state_in = S_WALK;
                     if (op_ff == OP_PRE) begin
                        if (pres(vld_ff, l2, limit)) begin cur_in = l2[7:0]; state_in = S_DONE; end
                        else if (pres(vld_ff, r2, limit)) begin
                           cur_in = r2[7:0]; state_in = S_DONE;
                        end
                     end else if (op_ff == OP_IN) begin
                        if (pres(vld_ff, r2, limit)) begin cur_in = r2[7:0]; acc_in = 8'd1; end
                     end else begin
                        if (a_ff <= 1) begin st_in = ST_NOSUCC; cur_in = '0; state_in = S_DONE; end
                        else if (a_ff[0] || !pres(vld_ff, {1'b0, a_ff[7:1], 1'b1}, limit)) begin
                           cur_in = {1'b0, a_ff[7:1]}; state_in = S_DONE;
                        end else cur_in = {a_ff[7:1], 1'b1};
                     end
                  end
               endcase
            end
         end
         S_SW0: begin cmd.rd_alt = 1'b1; cmd.cap_a = 1'b1; state_in = S_SW1; end
         S_SW1: begin cmd.cap_b = 1'b1; state_in = S_CLR; end
         S_CLR: begin
            if (!acc_ff[0]) begin cmd.wr_swap_a = 1'b1; acc_in = 8'd1; end
            else begin cmd.wr_swap_b = 1'b1; acc_in = '0; state_in = S_DONE; end
         end
         S_RD2: begin
            if (op_ff == OP_SETL || op_ff == OP_SETR || op_ff == OP_INIT) begin
               vld_in[b_ff] = 1'b1; cmd.wr_a = 1'b1; state_in = S_DONE;
            end else begin cmd.rd_alt = 1'b1; ui_in = 1'b1; state_in = S_RD; end
         end
         S_RD: state_in = S_DONE;
         S_WALK: begin
            case (op_ff)
               OP_DEPTH: begin
                  if (cur_ff > 1) begin cur_in = cur_ff >> 1; acc_in = acc_ff + 8'd1; end
                  else begin cur_in = '0; state_in = S_DONE; end
               end
               OP_PRE: begin
                  if (cur_ff <= 1) begin st_in = ST_NOSUCC; cur_in = '0; state_in = S_DONE; end
                  else if (pres(vld_ff, pr, limit) && {1'b0, cur_ff} != pr) begin
                     cur_in = pr[7:0]; state_in = S_DONE;
                  end else cur_in = pp[7:0];
               end
               OP_IN: begin
                  if (acc_ff[0]) begin
                     if (pres(vld_ff, lc, limit)) cur_in = lc[7:0];
                     else begin acc_in = '0; state_in = S_DONE; end
                  end else if (cur_ff <= 1) begin
                     st_in = ST_NOSUCC; cur_in = '0; state_in = S_DONE;
                  end else if (!cur_ff[0]) begin cur_in = pp[7:0]; state_in = S_DONE; end
                  else cur_in = pp[7:0];
               end
               default: begin
                  if (pres(vld_ff, lc, limit)) cur_in = lc[7:0];
                  else if (pres(vld_ff, rc, limit)) cur_in = rc[7:0];
                  else state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            // with ph_ff low the child entries are read, with ph_ff high the node is written
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (sc == a_ff) begin
                  acc_in = (op_ff == OP_HEIGHT) ? hgt_wr : siz_wr; state_in = S_DONE;
               end else scan_in = scan_ff - 9'd1;
            end
         end
         S_DONE: begin
            if (!rv_ff) begin
               rv_in = 1'b1; state_in = S_IDLE;
               if (st_ff != ST_OK) begin ui_in = 1'b0; cur_in = '0; acc_in = '0; end
               if (op_ff != OP_PRE && op_ff != OP_IN && op_ff != OP_POST) cur_in = '0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; cur_ff <= cur_in; acc_ff <= acc_in;
      scan_ff <= scan_in; st_ff <= st_in; ui_ff <= ui_in; ph_ff <= ph_in;
   end
endmodule
